// ===== rtl/svt_pkg.sv =====
// shared constants, codes and control/status types for the sampler voice table
package svt_pkg;

	localparam int MAX_VOICES_DEF  = 16;
	localparam int CURSOR_BITS_DEF = 24;

	// command kinds
	localparam logic [2:0] KIND_PLAY    = 3'd0;
	localparam logic [2:0] KIND_STOP    = 3'd1;
	localparam logic [2:0] KIND_SET_VOL = 3'd2;
	localparam logic [2:0] KIND_SET_PAN = 3'd3;
	localparam logic [2:0] KIND_ADVANCE = 3'd4;
	localparam logic [2:0] KIND_READ    = 3'd5;

	// error codes
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_PARAM    = 2'd1;
	localparam logic [1:0] ERR_NO_VOICE = 2'd2;

	// voice state codes
	localparam logic [1:0] VST_IDLE      = 2'd0;
	localparam logic [1:0] VST_PLAYING   = 2'd1;
	localparam logic [1:0] VST_BAD_INDEX = 2'd2;

	localparam logic [15:0] REPS_FOREVER = 16'hFFFF;

	localparam logic [4:0] VOICES_IN_USE_RST = 5'd16;

	typedef struct packed {
		logic capture;
		logic rd;
		logic scan_step;
		logic play_commit;
		logic exec_commit;
	} svt_cmd_t;

	typedef struct packed {
		logic is_play;
		logic loop_bad;
		logic scan_end;
		logic scan_free;
	} svt_stat_t;

endpackage

// ===== rtl/sampler_voice_table_unit.sv =====
// sampler voice table: allocation, control and loop playback of sampler voices
// stop, set, advance, read: capture, decode and execute steps, then the done strobe
// play: capture and decode, then the free-voice scan up to a free voice, the end of the
//   voices in use or a loop start above its end; the free-voice scan checks one voice per cycle
// one word at a time; start is taken again in the cycle done is high
// reset: arst_n clears every voice to idle and sets voices_in_use to 16; results cannot stall
module sampler_voice_table_unit import svt_pkg::*; #(
	parameter int MAX_VOICES  = MAX_VOICES_DEF,
	parameter int CURSOR_BITS = CURSOR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [3:0]         voice,
	input  logic [7:0]         sample_id,
	input  logic [23:0]        sample_length,
	input  logic [15:0]        volume,
	input  logic signed [15:0] pan,
	input  logic [23:0]        loop_from,
	input  logic [23:0]        loop_to,
	input  logic signed [15:0] repetitions,
	input  logic [15:0]        frames,
	// voices_in_use register
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	// result side, one word per done strobe
	output logic               done,
	output logic [1:0]         error_code,
	output logic [3:0]         voice_out,
	output logic [1:0]         voice_state,
	output logic [23:0]        cursor_out,
	output logic [7:0]         sample_out,
	output logic               still_playing
);

	// command and status between controller and datapath
	svt_cmd_t  cmd;
	svt_stat_t stat;

	// controller: idle, decode, free-voice scan, execute
	svt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: voice memory with valid and busy bits, scan counter, result registers
	svt_dp #(
		.MAX_VOICES  (MAX_VOICES),
		.CURSOR_BITS (CURSOR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.voice         (voice),
		.sample_id     (sample_id),
		.sample_length (sample_length),
		.volume        (volume),
		.pan           (pan),
		.loop_from     (loop_from),
		.loop_to       (loop_to),
		.repetitions   (repetitions),
		.frames        (frames),
		.error_code    (error_code),
		.voice_out     (voice_out),
		.voice_state   (voice_state),
		.cursor_out    (cursor_out),
		.sample_out    (sample_out),
		.still_playing (still_playing)
	);

endmodule

// ===== rtl/svt_ctrl.sv =====
// controller state machine for the sampler voice table
module svt_ctrl import svt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  svt_stat_t stat,
	output svt_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   scan_stop;

	assign scan_stop = stat.loop_bad || stat.scan_end || stat.scan_free;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.capture = start;
			S_DECODE: cmd.rd = !stat.is_play;
			S_SCAN: begin
				cmd.play_commit = scan_stop;
				cmd.scan_step   = !scan_stop;
			end
			S_EXEC:   cmd.exec_commit = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= stat.is_play ? S_SCAN : S_EXEC;
				end
				S_SCAN: begin
					if (scan_stop) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/svt_dp.sv =====
// datapath of the sampler voice table: voice memory, scan counter, result registers
module svt_dp import svt_pkg::*; #(
	parameter int MAX_VOICES  = MAX_VOICES_DEF,
	parameter int CURSOR_BITS = CURSOR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  svt_cmd_t           cmd,
	output svt_stat_t          stat,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic [2:0]         kind,
	input  logic [3:0]         voice,
	input  logic [7:0]         sample_id,
	input  logic [23:0]        sample_length,
	input  logic [15:0]        volume,
	input  logic signed [15:0] pan,
	input  logic [23:0]        loop_from,
	input  logic [23:0]        loop_to,
	input  logic signed [15:0] repetitions,
	input  logic [15:0]        frames,
	output logic [1:0]         error_code,
	output logic [3:0]         voice_out,
	output logic [1:0]         voice_state,
	output logic [23:0]        cursor_out,
	output logic [7:0]         sample_out,
	output logic               still_playing
);

	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int NW = $clog2(MAX_VOICES + 1);
	localparam int CB = CURSOR_BITS;
	localparam logic [32:0] CMAX_W = (33'd1 << CB) - 33'd1;

	typedef struct packed {
		logic [7:0]    sample;
		logic [CB-1:0] cursor;
		logic [15:0]   vol;
		logic [15:0]   pan;
		logic [CB-1:0] lbeg;
		logic [CB-1:0] lfin;
		logic [15:0]   reps;
	} entry_t;

	// captured command word
	logic [2:0]  kind_q;
	logic [3:0]  voice_q;
	logic [7:0]  sample_id_q;
	logic [23:0] length_q;
	logic [15:0] volume_q;
	logic [15:0] pan_q;
	logic [23:0] lstart_q;
	logic [23:0] lend_q;
	logic [15:0] reps_q;
	logic [15:0] frames_q;

	logic [4:0]            voices_in_use_q;
	logic [NW-1:0]         scan_cnt_q;
	logic [MAX_VOICES-1:0] valid_q;
	logic [MAX_VOICES-1:0] busy_q;

	entry_t mem [MAX_VOICES];
	entry_t rd_q;
	logic   rd_vld_q;

	logic [1:0]  err_q;
	logic [3:0]  vout_q;
	logic [1:0]  vstate_q;
	logic [23:0] cur_q;
	logic [7:0]  smp_q;
	logic        still_q;

	logic [NW-1:0] n_act;
	logic [VW-1:0] scan_idx;
	logic [VW-1:0] vaddr;
	logic          scan_end;
	logic          loop_bad;
	logic          voice_bad;
	logic [23:0]   lend_eff;

	function automatic logic [CB-1:0] clamp_c(input logic [23:0] x);
		return (33'(x) > CMAX_W) ? CB'(CMAX_W) : CB'(x);
	endfunction

	always_comb begin
		if (7'(voices_in_use_q) < 7'(MAX_VOICES)) n_act = NW'(voices_in_use_q);
		else n_act = NW'(MAX_VOICES);
	end

	assign scan_idx  = scan_cnt_q[VW-1:0];
	assign vaddr     = VW'(voice_q);
	assign scan_end  = 7'(scan_cnt_q) >= 7'(n_act);
	assign loop_bad  = lstart_q > lend_q;
	assign voice_bad = (kind_q > KIND_READ) || (7'(voice_q) >= 7'(n_act));
	assign lend_eff  = (lend_q == 24'd0) ? length_q : lend_q;

	assign stat.is_play   = (kind_q == KIND_PLAY);
	assign stat.loop_bad  = loop_bad;
	assign stat.scan_end  = scan_end;
	assign stat.scan_free = !scan_end && !busy_q[scan_idx];

	// entry written by a play
	entry_t play_e;
	always_comb begin
		play_e.sample = sample_id_q;
		play_e.cursor = '0;
		play_e.vol    = volume_q;
		play_e.pan    = pan_q;
		play_e.lbeg   = clamp_c(lstart_q);
		play_e.lfin   = clamp_c(lend_eff);
		play_e.reps   = reps_q;
	end

	// read-modify-write of the addressed voice
	entry_t        cur_e;
	entry_t        new_e;
	logic [32:0]   adv_sum;
	logic [CB-1:0] adv_cur;
	logic [16:0]   reps_dec;
	logic          ex_still;
	logic          ex_write;
	logic          ex_clear;

	always_comb begin
		cur_e    = rd_vld_q ? rd_q : '0;
		new_e    = cur_e;
		ex_still = 1'b0;
		ex_write = 1'b0;
		ex_clear = 1'b0;
		adv_sum  = 33'(cur_e.cursor) + 33'(frames_q);
		adv_cur  = (adv_sum > CMAX_W) ? CB'(CMAX_W) : CB'(adv_sum);
		reps_dec = {cur_e.reps[15], cur_e.reps} - 17'd1;
		if (!voice_bad) begin
			case (kind_q)
				KIND_STOP: begin
					new_e    = '0;
					ex_clear = 1'b1;
				end
				KIND_SET_VOL: begin
					new_e.vol = volume_q;
					ex_write  = 1'b1;
				end
				KIND_SET_PAN: begin
					new_e.pan = pan_q;
					ex_write  = 1'b1;
				end
				KIND_ADVANCE: begin
					if (cur_e.reps != 16'd0) begin
						ex_write     = 1'b1;
						ex_still     = 1'b1;
						new_e.cursor = adv_cur;
						// loop end reached: rewind and count the pass
						if ((cur_e.lfin != '0) && (adv_cur >= cur_e.lfin)) begin
							new_e.cursor = cur_e.lbeg;
							if (cur_e.reps != REPS_FOREVER) begin
								if (reps_dec[16] || (reps_dec == 17'd0)) begin
									new_e.reps = 16'd0;
									ex_still   = 1'b0;
								end else begin
									new_e.reps = reps_dec[15:0];
								end
							end
						end
					end
				end
				default: new_e = cur_e;
			endcase
		end
	end

	// single write port
	logic          wr_en;
	logic [VW-1:0] wr_addr;
	entry_t        wr_data;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = vaddr;
		wr_data = new_e;
		if (cmd.play_commit) begin
			wr_en   = !loop_bad && !scan_end;
			wr_addr = scan_idx;
			wr_data = play_e;
		end else if (cmd.exec_commit) begin
			wr_en = ex_write;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_q <= mem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q      <= kind;
			voice_q     <= voice;
			sample_id_q <= sample_id;
			length_q    <= sample_length;
			volume_q    <= volume;
			pan_q       <= pan;
			lstart_q    <= loop_from;
			lend_q      <= loop_to;
			reps_q      <= repetitions;
			frames_q    <= frames;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voices_in_use_q <= VOICES_IN_USE_RST;
			scan_cnt_q      <= '0;
			valid_q         <= '0;
			busy_q          <= '0;
			rd_vld_q        <= 1'b0;
		end else begin
			if (cfg_we) voices_in_use_q <= cfg_wdata;
			if (cmd.capture) scan_cnt_q <= '0;
			else if (cmd.scan_step) scan_cnt_q <= scan_cnt_q + NW'(1);
			if (cmd.rd) rd_vld_q <= valid_q[vaddr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				busy_q[wr_addr]  <= (wr_data.reps != 16'd0);
			end
			if (cmd.exec_commit && ex_clear) begin
				valid_q[vaddr] <= 1'b0;
				busy_q[vaddr]  <= 1'b0;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.play_commit) begin
			still_q <= 1'b0;
			if (loop_bad || scan_end) begin
				err_q    <= loop_bad ? ERR_PARAM : ERR_NO_VOICE;
				vout_q   <= 4'd0;
				vstate_q <= VST_IDLE;
				cur_q    <= 24'd0;
				smp_q    <= 8'd0;
			end else begin
				err_q    <= ERR_OK;
				vout_q   <= 4'(scan_cnt_q);
				vstate_q <= (reps_q != 16'd0) ? VST_PLAYING : VST_IDLE;
				cur_q    <= 24'd0;
				smp_q    <= sample_id_q;
			end
		end else if (cmd.exec_commit) begin
			vout_q <= voice_q;
			if (voice_bad) begin
				err_q    <= ERR_PARAM;
				vstate_q <= VST_BAD_INDEX;
				cur_q    <= 24'd0;
				smp_q    <= 8'd0;
				still_q  <= 1'b0;
			end else begin
				err_q    <= ERR_OK;
				vstate_q <= (new_e.reps != 16'd0) ? VST_PLAYING : VST_IDLE;
				cur_q    <= 24'(new_e.cursor);
				smp_q    <= new_e.sample;
				still_q  <= ex_still;
			end
		end
	end

	assign error_code    = err_q;
	assign voice_out     = vout_q;
	assign voice_state   = vstate_q;
	assign cursor_out    = cur_q;
	assign sample_out    = smp_q;
	assign still_playing = still_q;

endmodule

// ===== dv/sampler_voice_table_unit_test.sv =====
// self-checking testbench for the sampler voice table unit
`timescale 1ns / 1ps

import svt_pkg::*;

typedef struct {
	logic [2:0]         kind;
	logic [3:0]         voice;
	logic [7:0]         sample_id;
	logic [23:0]        sample_length;
	logic [15:0]        volume;
	logic signed [15:0] pan;
	logic [23:0]        loop_from;
	logic [23:0]        loop_to;
	logic signed [15:0] repetitions;
	logic [15:0]        frames;
} voice_cmd_t;

typedef struct {
	logic [1:0]  err;
	logic [3:0]  voice;
	logic [1:0]  state;
	logic [23:0] cursor;
	logic [7:0]  sample;
	logic        still;
} voice_status_t;

// voice table predictor plus the queue of status words still owed by the block
class voice_table_scoreboard;
	logic [7:0]         sample_of [MAX_VOICES_DEF];
	logic [23:0]        cursor_of [MAX_VOICES_DEF];
	logic [15:0]        volume_of [MAX_VOICES_DEF];
	logic signed [15:0] pan_of    [MAX_VOICES_DEF];
	logic [23:0]        loop_lo   [MAX_VOICES_DEF];
	logic [23:0]        loop_hi   [MAX_VOICES_DEF];
	logic signed [15:0] repeats   [MAX_VOICES_DEF];
	logic [4:0]         voices_in_use;
	voice_status_t      expected_status [$];
	int                 mismatches;

	function new();
		for (int i = 0; i < MAX_VOICES_DEF; i++)
			clear_voice(i);
		voices_in_use = VOICES_IN_USE_RST;
		mismatches = 0;
	endfunction

	function void clear_voice(int v);
		sample_of[v] = '0;
		cursor_of[v] = '0;
		volume_of[v] = '0;
		pan_of[v]    = '0;
		loop_lo[v]   = '0;
		loop_hi[v]   = '0;
		repeats[v]   = '0;
	endfunction

	// apply one accepted command word and queue the status it must produce
	function void note_command(voice_cmd_t c);
		voice_status_t s;
		int unsigned   n;
		int unsigned   slot;
		int unsigned   v;
		logic [24:0]   sum;
		int            r;
		s.err    = ERR_OK;
		s.voice  = c.voice;
		s.state  = VST_BAD_INDEX;
		s.cursor = '0;
		s.sample = '0;
		s.still  = 1'b0;
		n = voices_in_use > MAX_VOICES_DEF ? MAX_VOICES_DEF : voices_in_use;
		v = c.voice;
		if (c.kind == KIND_PLAY) begin
			s.voice = '0;
			s.state = VST_IDLE;
			if (c.loop_from > c.loop_to) begin
				s.err = ERR_PARAM;
			end else begin
				slot = 0;
				while (slot < n && repeats[slot] != 0)
					slot++;
				if (slot >= n) begin
					s.err = ERR_NO_VOICE;
				end else begin
					sample_of[slot] = c.sample_id;
					cursor_of[slot] = '0;
					volume_of[slot] = c.volume;
					pan_of[slot]    = c.pan;
					loop_lo[slot]   = c.loop_from;
					loop_hi[slot]   = c.loop_to == 0 ? c.sample_length : c.loop_to;
					repeats[slot]   = c.repetitions;
					s.voice  = 4'(slot);
					s.state  = repeats[slot] != 0 ? VST_PLAYING : VST_IDLE;
					s.sample = c.sample_id;
				end
			end
		end else if (c.kind > KIND_READ || v >= n) begin
			s.err = ERR_PARAM;
		end else begin
			case (c.kind)
				KIND_STOP: clear_voice(v);
				KIND_SET_VOL: volume_of[v] = c.volume;
				KIND_SET_PAN: pan_of[v] = c.pan;
				KIND_ADVANCE: begin
					if (repeats[v] != 0) begin
						sum = {1'b0, cursor_of[v]} + 25'(c.frames);
						cursor_of[v] = sum[24] ? 24'hFFFFFF : sum[23:0];
						s.still = 1'b1;
						if (loop_hi[v] != 0 && cursor_of[v] >= loop_hi[v]) begin
							cursor_of[v] = loop_lo[v];
							if (repeats[v] != REPS_FOREVER) begin
								r = int'(repeats[v]) - 1;
								if (r <= 0) begin
									repeats[v] = '0;
									s.still = 1'b0;
								end else begin
									repeats[v] = 16'(r);
								end
							end
						end
					end
				end
				default: ;
			endcase
			s.state  = repeats[v] != 0 ? VST_PLAYING : VST_IDLE;
			s.cursor = cursor_of[v];
			s.sample = sample_of[v];
		end
		expected_status.push_back(s);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_status(voice_status_t got);
		voice_status_t want;
		if (expected_status.size() == 0) begin
			$error("status word with nothing pending, voice_out %0d", got.voice);
			mismatches++;
			return;
		end
		want = expected_status.pop_front();
		compare_field("error_code", want.err, got.err);
		compare_field("voice_out", want.voice, got.voice);
		compare_field("voice_state", want.state, got.state);
		compare_field("cursor_out", want.cursor, got.cursor);
		compare_field("sample_out", want.sample, got.sample);
		compare_field("still_playing", want.still, got.still);
	endfunction
endclass

module sampler_voice_table_unit_test;

	localparam int LIMIT = 300_000;
	// kinds the block must reject
	localparam logic [2:0] KIND_BAD_LO = 3'd6;
	localparam logic [2:0] KIND_BAD_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         kind;
	logic [3:0]         voice;
	logic [7:0]         sample_id;
	logic [23:0]        sample_length;
	logic [15:0]        volume;
	logic signed [15:0] pan;
	logic [23:0]        loop_from;
	logic [23:0]        loop_to;
	logic signed [15:0] repetitions;
	logic [15:0]        frames;
	logic               cfg_we;
	logic [4:0]         cfg_wdata;
	logic               done;
	logic [1:0]         error_code;
	logic [3:0]         voice_out;
	logic [1:0]         voice_state;
	logic [23:0]        cursor_out;
	logic [7:0]         sample_out;
	logic               still_playing;

	voice_cmd_t            drv;
	voice_status_t         observed;
	voice_table_scoreboard sb;
	int                    cycles = 0;

	// command fields all come from one struct so the monitor sees what the ports see
	assign kind          = drv.kind;
	assign voice         = drv.voice;
	assign sample_id     = drv.sample_id;
	assign sample_length = drv.sample_length;
	assign volume        = drv.volume;
	assign pan           = drv.pan;
	assign loop_from     = drv.loop_from;
	assign loop_to       = drv.loop_to;
	assign repetitions   = drv.repetitions;
	assign frames        = drv.frames;

	sampler_voice_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.voice         (voice),
		.sample_id     (sample_id),
		.sample_length (sample_length),
		.volume        (volume),
		.pan           (pan),
		.loop_from     (loop_from),
		.loop_to       (loop_to),
		.repetitions   (repetitions),
		.frames        (frames),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.error_code    (error_code),
		.voice_out     (voice_out),
		.voice_state   (voice_state),
		.cursor_out    (cursor_out),
		.sample_out    (sample_out),
		.still_playing (still_playing)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("sampler_voice_table_unit_test: FAIL");
			$finish;
		end
	end

	// monitor: values read here are the ones present before the edge
	// the result word is checked first, the new command then updates the table
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				observed.err    = error_code;
				observed.voice  = voice_out;
				observed.state  = voice_state;
				observed.cursor = cursor_out;
				observed.sample = sample_out;
				observed.still  = still_playing;
				sb.check_status(observed);
			end
			if (start && !busy)
				sb.note_command(drv);
		end
	end

	function automatic voice_cmd_t cmd(logic [2:0] k, logic [3:0] v, logic [7:0] sid,
		logic [23:0] len, logic [15:0] vol, logic signed [15:0] p, logic [23:0] ls,
		logic [23:0] le, logic signed [15:0] reps, logic [15:0] fr);
		voice_cmd_t c;
		c.kind          = k;
		c.voice         = v;
		c.sample_id     = sid;
		c.sample_length = len;
		c.volume        = vol;
		c.pan           = p;
		c.loop_from     = ls;
		c.loop_to       = le;
		c.repetitions   = reps;
		c.frames        = fr;
		return c;
	endfunction

	// mostly well-formed traffic on live voices, some rejected plays and raw noise
	function automatic voice_cmd_t random_command();
		voice_cmd_t  c;
		int unsigned n;
		int unsigned pick;
		int unsigned mode;
		n = sb.voices_in_use > MAX_VOICES_DEF ? MAX_VOICES_DEF : sb.voices_in_use;
		c.kind          = 3'($urandom);
		c.sample_id     = 8'($urandom);
		c.sample_length = 24'($urandom);
		c.volume        = 16'($urandom);
		c.pan           = 16'($urandom);
		c.loop_from     = 24'($urandom);
		c.loop_to       = 24'($urandom);
		c.repetitions   = 16'($urandom);
		c.frames        = 16'($urandom);
		// mostly a voice that is in range
		if (n != 0 && $urandom_range(0, 9) != 0)
			c.voice = 4'($urandom_range(0, n - 1));
		else
			c.voice = 4'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			c.kind = KIND_PLAY;
			mode = $urandom_range(0, 9);
			if (mode <= 5) begin
				// short loop so that advances wrap often
				c.loop_to   = 24'($urandom_range(1, 300));
				c.loop_from = 24'($urandom_range(0, c.loop_to));
			end else if (mode == 6) begin
				// loop end taken from the sample length, possibly no loop at all
				c.loop_to       = '0;
				c.loop_from     = '0;
				c.sample_length = 24'($urandom_range(0, 400));
			end else if (mode == 8) begin
				// start past end
				c.loop_to   = 24'($urandom_range(0, 1000));
				c.loop_from = c.loop_to + 24'($urandom_range(1, 50));
			end else if (mode == 9) begin
				c.loop_to   = 24'hFFFFFF - 24'($urandom_range(0, 5));
				c.loop_from = 24'($urandom_range(0, c.loop_to));
			end
			mode = $urandom_range(0, 9);
			if (mode == 0)
				c.repetitions = '0;
			else if (mode <= 5)
				c.repetitions = 16'($urandom_range(1, 4));
			else if (mode <= 7)
				c.repetitions = -16'sd1;
			else if (mode == 9)
				c.repetitions = -16'($urandom_range(2, 5));
		end else if (pick < 60) begin
			c.kind = KIND_ADVANCE;
			if ($urandom_range(0, 4) != 0)
				c.frames = 16'($urandom_range(0, 150));
		end else if (pick < 70) begin
			c.kind = KIND_READ;
		end else if (pick < 82) begin
			c.kind = KIND_STOP;
		end else if (pick < 87) begin
			c.kind = KIND_SET_VOL;
		end else if (pick < 92) begin
			c.kind = KIND_SET_PAN;
		end
		return c;
	endfunction

	// present one word and hold it until the block takes it; start stays high on return
	task automatic send(voice_cmd_t c);
		drv   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic wait_drained();
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	// register writes only with the block empty
	task automatic configure(logic [4:0] value);
		if (start)
			start <= 1'b0;
		// let the monitor log a word taken at this edge before looking at the queue
		@(posedge clk);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.voices_in_use = value;
	endtask

	task automatic run_random(int count, int idle_pct);
		for (int i = 0; i < count; i++) begin
			send(random_command());
			if ($urandom_range(0, 99) < idle_pct) begin
				// gap long enough to cover a full free-voice scan now and then
				start <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else if ($urandom_range(0, 59) == 0) begin
				// hold off until every pending status word is back
				start <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
		end
	endtask

	initial begin
		sb        = new();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		drv       <= cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, all sixteen voices in use after reset
		send(cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// zero repetitions: voice filled but idle, zero loop end takes the length
		send(cmd(KIND_PLAY, 9, 8'hFF, 24'hFFFFFF, 16'hFFFF, 16'h7FFF, 0, 0, 0, 16'hFFFF));
		// loop start above loop end
		send(cmd(KIND_PLAY, 0, 1, 100, 0, 0, 11, 10, 3, 0));
		send(cmd(KIND_PLAY, 0, 8'h12, 0, 16'hFFFF, -32768, 5, 10, 2, 0));
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 12));
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// last pass ends, voice goes idle
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		// advance on an idle voice
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 3));
		// forever loop ending at the sample length
		send(cmd(KIND_PLAY, 0, 3, 100, 0, 0, 0, 0, -1, 0));
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 250));
		// negative count other than forever ends at the first loop end
		send(cmd(KIND_PLAY, 0, 4, 0, 0, 0, 0, 20, -5, 0));
		send(cmd(KIND_ADVANCE, 1, 0, 0, 0, 0, 0, 0, 0, 30));
		send(cmd(KIND_PLAY, 0, 5, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 16'h7FFF, 0));
		send(cmd(KIND_ADVANCE, 1, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		send(cmd(KIND_SET_VOL, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_SET_PAN, 1, 0, 0, 0, 32767, 0, 0, 0, 0));
		send(cmd(KIND_SET_PAN, 1, 0, 0, 0, -1, 0, 0, 0, 0));
		send(cmd(KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		// unknown kinds
		send(cmd(KIND_BAD_LO, 3, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_BAD_HI, 15, 8'hFF, 24'hFFFFFF, 16'hFFFF, -1, 24'hFFFFFF, 24'hFFFFFF,
			-1, 16'hFFFF));
		// most negative count, one-frame loop
		send(cmd(KIND_PLAY, 0, 6, 24'hFFFFFF, 0, 0, 0, 1, -32768, 0));
		send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send(cmd(KIND_STOP, 15, 0, 0, 0, 0, 0, 0, 0, 0));

		// single voice: drive a loopless voice into cursor saturation
		configure(5'd1);
		send(cmd(KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(cmd(KIND_PLAY, 0, 8'hA5, 0, 0, 0, 0, 0, -1, 0));
		for (int i = 0; i < 260; i++)
			send(cmd(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		send(cmd(KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		run_random(120, 29);

		// no voice usable at all
		configure(5'd0);
		run_random(40, 29);

		configure(5'd16);
		run_random(300, 29);

		// above the table size, clipped to sixteen
		configure(5'd31);
		run_random(200, 62);

		configure(5'($urandom_range(2, 15)));
		run_random(180, 0);

		if (start)
			start <= 1'b0;
		wait_drained();
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_status.size() == 0)
			$display("sampler_voice_table_unit_test: PASS");
		else
			$display("sampler_voice_table_unit_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/svt_pkg.sv
rtl/svt_ctrl.sv
rtl/svt_dp.sv
rtl/sampler_voice_table_unit.sv
dv/sampler_voice_table_unit_test.sv
